### design/vad_pkg.sv
// Shared types and constants for the voice activity decision block.
`timescale 1ns / 1ps
`default_nettype none
package vad_pkg;

	localparam int NUM_FEAT = 4;

	typedef logic [15:0] feat_t;
	typedef logic [1:0]  op_t;

	// operation codes
	localparam op_t OP_CALIB   = 2'd0;
	localparam op_t OP_DETECT  = 2'd1;
	localparam op_t OP_RESTART = 2'd2;
	localparam op_t OP_UNUSED  = 2'd3;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_WEIGHTS = 2'd0;
	localparam logic [1:0] REG_MARGINS = 2'd1;
	localparam logic [1:0] REG_RATIO   = 2'd2;

	localparam logic [31:0] WEIGHTS_RST = 32'h4040_4040;
	localparam logic [31:0] MARGINS_RST = 32'h1818_1818;
	localparam logic [7:0]  RATIO_RST   = 8'd128;

	// energy, centroid, crossing, variance
	localparam feat_t LIMIT_RST [NUM_FEAT] = '{16'd328, 16'd1000, 16'd655, 16'd26};
	localparam feat_t LIMIT_FLOOR [NUM_FEAT] = '{16'd131, 16'd800, 16'd328, 16'd13};

	// vote threshold on the weight sum, Q0.8
	localparam logic [9:0] VOTE_LEVEL = 10'd128;

endpackage
`default_nettype wire

### design/vad_sort_cell.sv
// One cell of the insertion-sort row: holds a value; if > x, on insert takes left's or x.
`timescale 1ns / 1ps
`default_nettype none
module vad_sort_cell
	import vad_pkg::*;
(
	input  wire   clk,
	input  wire   insert,
	input  wire   valid,
	input  feat_t x,
	input  wire   left_gt,
	input  feat_t left_val,
	output logic  gt,
	output feat_t val
);

	feat_t val_q;

	// empty cells act as +infinity
	assign gt  = !valid || (val_q > x);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (insert && gt) begin
			val_q <= left_gt ? left_val : x;
		end
	end

endmodule
`default_nettype wire

### design/vad_sort_lane.sv
// Sorted row of cells for one feature plus the percentile threshold math.
`timescale 1ns / 1ps
`default_nettype none
module vad_sort_lane
	import vad_pkg::*;
#(
	parameter int N = 64,
	localparam int CNT_W = $clog2(N + 1)
) (
	input  wire               clk,
	input  wire               insert,
	input  wire  [CNT_W-1:0]  count,
	input  feat_t             x,
	input  wire  [7:0]        margin,
	input  feat_t             floor_val,
	output feat_t             limit
);

	localparam int RANK = (95 * (N - 1)) / 100;

	logic  gt  [N];
	feat_t val [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic  lgt;
		feat_t lval;
		if (i == 0) begin : g_head
			assign lgt  = 1'b0;
			assign lval = x;
		end else begin : g_body
			assign lgt  = gt[i-1];
			assign lval = val[i-1];
		end
		vad_sort_cell u_cell (
			.clk     (clk),
			.insert  (insert),
			.valid   (CNT_W'(i) < count),
			.x       (x),
			.left_gt (lgt),
			.left_val(lval),
			.gt      (gt[i]),
			.val     (val[i])
		);
	end

	logic [23:0] prod;
	logic [19:0] scaled;
	feat_t       sat;

	always_comb begin
		prod   = 24'(val[RANK]) * 24'(margin);
		scaled = prod[23:4];
		sat    = (scaled > 20'hFFFF) ? 16'hFFFF : scaled[15:0];
		limit  = (sat > floor_val) ? sat : floor_val;
	end

endmodule
`default_nettype wire

### design/voice_activity_decision.sv
// Top level of the voice activity decision block.
`timescale 1ns / 1ps
`default_nettype none
// Voice activity decision back end. Each input word carries an operation and
// four frame features (energy, centroid, crossing rate, spectral variance).
// Calibration words are inserted into four sorted rows of CALIBRATION_COUNT
// cells, one row per feature; each cell compares the new sample with its own
// value and takes its left neighbor's or the sample, so the row sorts each
// sample in parallel. When the last sample lands, the 95th-percentile cell of
// each row is scaled by its Q4.4 margin, floored, and loaded as the feature's
// threshold. Detect words compare features with the thresholds, add the Q0.8
// weights of exceeded ones, vote active above 0.5 and push the vote into a
// HISTORY_DEPTH ring; is_active is set when the ring's active share exceeds
// activity_ratio. Restart only clears the calibrated flag and the count.
// A word is captured in IDLE, then executed in EXEC; the calibration word
// that completes the store also passes LIMIT for the threshold multiply.
// The next input word is accepted on the cycle after execution, even while
// the previous result waits in the output register. Registers: 0x0 weights,
// 0x4 margins, 0x8 ratio; configure only while idle.
module voice_activity_decision
	import vad_pkg::*;
#(
	parameter int CALIBRATION_COUNT = 64,
	parameter int HISTORY_DEPTH     = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// input channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  operation,
	input  wire  [15:0] energy_level,
	input  wire  [15:0] centroid_hz,
	input  wire  [15:0] crossing_rate,
	input  wire  [15:0] log_spectrum_variance,
	// output channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic        is_active,
	output logic [9:0]  confidence,
	output logic        calibrated,
	output logic [6:0]  calibration_progress,
	// config port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W  = $clog2(CALIBRATION_COUNT + 1);
	localparam int HP_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HC_W   = $clog2(HISTORY_DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	logic [1:0] state_q;

	// config registers
	logic [31:0] weights_q;
	logic [31:0] margins_q;
	logic [7:0]  ratio_q;

	// captured word
	op_t   op_q;
	feat_t feat_q [NUM_FEAT];

	// block state
	logic             done_q;
	logic [CNT_W-1:0] count_q;
	feat_t            limit_q [NUM_FEAT];
	logic [HISTORY_DEPTH-1:0] hist_q;
	logic [HP_W-1:0]  ptr_q;

	feat_t lane_limit [NUM_FEAT];

	// ---------------- config port ----------------
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_WEIGHTS: prdata = weights_q;
			REG_MARGINS: prdata = margins_q;
			REG_RATIO:   prdata = {24'd0, ratio_q};
			default:     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= WEIGHTS_RST;
			margins_q <= MARGINS_RST;
			ratio_q   <= RATIO_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_WEIGHTS: weights_q <= pwdata;
				REG_MARGINS: margins_q <= pwdata;
				REG_RATIO:   ratio_q   <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	// ---------------- control ----------------
	logic in_acc;
	logic slot_free;
	logic do_insert;
	logic last_sample;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid || !out_stall;

	assign do_insert = (state_q == ST_EXEC) && slot_free && (op_q == OP_CALIB) && !done_q
		&& (count_q < CNT_W'(CALIBRATION_COUNT));
	assign last_sample = (count_q == CNT_W'(CALIBRATION_COUNT - 1));

	// sorted rows, one per feature
	for (genvar k = 0; k < NUM_FEAT; k++) begin : g_lane
		vad_sort_lane #(.N(CALIBRATION_COUNT)) u_lane (
			.clk      (clk),
			.insert   (do_insert),
			.count    (count_q),
			.x        (feat_q[k]),
			.margin   (margins_q[8*k +: 8]),
			.floor_val(LIMIT_FLOOR[k]),
			.limit    (lane_limit[k])
		);
	end

	// detect path
	logic [9:0]               conf;
	logic [HISTORY_DEPTH-1:0] hist_next;
	logic [HC_W-1:0]          hist_cnt;
	logic                     act;

	always_comb begin
		conf = 10'd0;
		for (int k = 0; k < NUM_FEAT; k++) begin
			if (feat_q[k] > limit_q[k]) begin
				conf = conf + 10'(weights_q[8*k +: 8]);
			end
		end
		hist_next        = hist_q;
		hist_next[ptr_q] = (conf > VOTE_LEVEL);
		hist_cnt         = HC_W'($countones(hist_next));
		act = ({8'd0, 16'(hist_cnt)} << 8) > (24'(ratio_q) * 24'(HISTORY_DEPTH));
	end

	logic [8:0] cnt_ext;
	logic [8:0] cnt_inc_ext;
	assign cnt_ext     = 9'(count_q);
	assign cnt_inc_ext = 9'(count_q) + 9'd1;

	// capture of the input word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q      <= operation;
			feat_q[0] <= energy_level;
			feat_q[1] <= centroid_hz;
			feat_q[2] <= crossing_rate;
			feat_q[3] <= log_spectrum_variance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			count_q   <= '0;
			hist_q    <= '0;
			ptr_q     <= '0;
			out_valid <= 1'b0;
			is_active <= 1'b0;
			confidence <= 10'd0;
			calibrated <= 1'b0;
			calibration_progress <= 7'd0;
			for (int k = 0; k < NUM_FEAT; k++) begin
				limit_q[k] <= LIMIT_RST[k];
			end
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (slot_free) begin
						out_valid  <= 1'b1;
						is_active  <= 1'b0;
						confidence <= 10'd0;
						calibrated <= done_q;
						calibration_progress <= cnt_ext[6:0];
						state_q    <= ST_IDLE;
						case (op_q)
							OP_CALIB: begin
								if (do_insert) begin
									count_q <= count_q + CNT_W'(1);
									calibration_progress <= cnt_inc_ext[6:0];
									if (last_sample) begin
										// thresholds are loaded in ST_LIMIT
										out_valid <= 1'b0;
										state_q   <= ST_LIMIT;
									end
								end
							end
							OP_DETECT: begin
								if (done_q) begin
									hist_q     <= hist_next;
									ptr_q      <= (ptr_q == HP_W'(HISTORY_DEPTH - 1)) ?
										'0 : ptr_q + HP_W'(1);
									is_active  <= act;
									confidence <= conf;
								end
							end
							OP_RESTART: begin
								done_q     <= 1'b0;
								count_q    <= '0;
								calibrated <= 1'b0;
								calibration_progress <= 7'd0;
							end
							default: ;
						endcase
					end
				end
				ST_LIMIT: begin
					if (slot_free) begin
						for (int k = 0; k < NUM_FEAT; k++) begin
							limit_q[k] <= lane_limit[k];
						end
						done_q     <= 1'b1;
						out_valid  <= 1'b1;
						is_active  <= 1'b0;
						confidence <= 10'd0;
						calibrated <= 1'b1;
						calibration_progress <= cnt_ext[6:0];
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// an uncalibrated result never carries a decision
	a_uncal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !calibrated |-> !is_active && (confidence == 10'd0))
		else $error("decision reported while uncalibrated");

	// the sample count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CALIBRATION_COUNT))
		else $error("calibration count overflow");

	// a threshold load sets the calibrated flag and posts a word
	a_limit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIMIT) && slot_free |=> done_q && out_valid && calibrated)
		else $error("threshold load did not complete calibration");
`endif

endmodule
`default_nettype wire

### tb/sv/voice_activity_decision_tb.sv
// Testbench for the voice activity decision block: directed table, saturating calibration, then random words.
`timescale 1ns / 1ps
`default_nettype none
module voice_activity_decision_tb;
	import vad_pkg::*;

	localparam int CAL_N = 64;
	localparam int HIST_N = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic       is_active;
		logic [9:0] confidence;
		logic       calibrated;
		logic [6:0] calibration_progress;
	} decision_t;

	// one row of the directed table; has_exp marks rows with a typed-in result
	typedef struct {
		op_t       op;
		feat_t     f [NUM_FEAT];
		bit        has_exp;
		decision_t exp;
	} stim_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic [1:0] operation;
	logic [15:0] energy_level, centroid_hz, crossing_rate, log_spectrum_variance;
	logic out_valid, out_stall;
	logic is_active, calibrated;
	logic [9:0] confidence;
	logic [6:0] calibration_progress;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;

	voice_activity_decision dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.energy_level(energy_level), .centroid_hz(centroid_hz),
		.crossing_rate(crossing_rate), .log_spectrum_variance(log_spectrum_variance),
		.out_valid(out_valid), .out_stall(out_stall),
		.is_active(is_active), .confidence(confidence), .calibrated(calibrated),
		.calibration_progress(calibration_progress),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [31:0] weights_q, margins_q;
	logic [7:0]  ratio_q;
	bit          cal_done;
	int unsigned sample_cnt;
	feat_t       cal_store [CAL_N][NUM_FEAT];
	feat_t       limit_q [NUM_FEAT];
	bit          vote_ring [HIST_N];
	int unsigned ring_ptr;

	decision_t   pending_decisions[$];
	bit          failed;
	int unsigned cycles;
	int unsigned send_idle_pct, recv_idle_pct;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("voice_activity_decision_tb NOT OK");
			$finish;
		end
	end

	// 95th percentile of one feature lane, scaled by margin, floored
	function automatic feat_t lane_threshold(int lane);
		int unsigned vals [CAL_N];
		int unsigned key, t, m;
		int j;
		for (int i = 0; i < CAL_N; i++) vals[i] = cal_store[i][lane];
		for (int i = 1; i < CAL_N; i++) begin
			key = vals[i];
			j = i;
			while (j > 0 && vals[j-1] > key) begin
				vals[j] = vals[j-1];
				j--;
			end
			vals[j] = key;
		end
		m = (margins_q >> (8 * lane)) & 8'hFF;
		t = (vals[(95 * (CAL_N - 1)) / 100] * m) >> 4;
		if (t > 16'hFFFF) t = 16'hFFFF;
		return (t > LIMIT_FLOOR[lane]) ? feat_t'(t) : LIMIT_FLOOR[lane];
	endfunction

	function automatic decision_t predict_decision(op_t op, feat_t f [NUM_FEAT]);
		decision_t d;
		int unsigned conf, votes;
		d = '0;
		conf = 0;
		case (op)
			OP_CALIB: begin
				if (!cal_done && sample_cnt < CAL_N) begin
					for (int k = 0; k < NUM_FEAT; k++) cal_store[sample_cnt][k] = f[k];
					sample_cnt++;
					if (sample_cnt >= CAL_N) begin
						for (int k = 0; k < NUM_FEAT; k++) limit_q[k] = lane_threshold(k);
						cal_done = 1;
					end
				end
			end
			OP_DETECT: begin
				if (cal_done) begin
					for (int k = 0; k < NUM_FEAT; k++)
						if (f[k] > limit_q[k]) conf += (weights_q >> (8 * k)) & 8'hFF;
					vote_ring[ring_ptr] = conf > VOTE_LEVEL;
					ring_ptr = (ring_ptr + 1) % HIST_N;
					votes = 0;
					for (int i = 0; i < HIST_N; i++) votes += vote_ring[i];
					d.is_active = votes * 256 > ratio_q * HIST_N;
					d.confidence = conf[9:0];
				end
			end
			OP_RESTART: begin
				cal_done = 0;
				sample_cnt = 0;
			end
			default: ;
		endcase
		d.calibrated = cal_done;
		d.calibration_progress = sample_cnt[6:0];
		return d;
	endfunction

	// APB write; predictor copy updated alongside
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_WEIGHTS: weights_q = val;
			REG_MARGINS: margins_q = val;
			REG_RATIO:   ratio_q = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drive one word; expectation is queued when the handshake completes
	task automatic send_word(op_t op, feat_t f [NUM_FEAT], bit has_exp, decision_t exp);
		decision_t d;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		operation <= op;
		energy_level <= f[0]; centroid_hz <= f[1];
		crossing_rate <= f[2]; log_spectrum_variance <= f[3];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		d = predict_decision(op, f);
		if (has_exp && d !== exp) begin
			$display("%0t table row disagrees with predictor: typed %p, predicted %p",
				$time, exp, d);
			failed = 1;
		end
		pending_decisions.push_back(d);
	endtask

	// receiver: random stall, compare each accepted word
	always @(posedge clk) begin
		decision_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{is_active, confidence, calibrated, calibration_progress};
				if (pending_decisions.size() == 0) begin
					$display("%0t unexpected result word %p", $time, got);
					failed = 1;
				end else begin
					want = pending_decisions.pop_front();
					if (got.is_active !== want.is_active)
						$display("%0t is_active exp %0d got %0d", $time,
							want.is_active, got.is_active);
					if (got.confidence !== want.confidence)
						$display("%0t confidence exp %0d got %0d", $time,
							want.confidence, got.confidence);
					if (got.calibrated !== want.calibrated)
						$display("%0t calibrated exp %0d got %0d", $time,
							want.calibrated, got.calibrated);
					if (got.calibration_progress !== want.calibration_progress)
						$display("%0t progress exp %0d got %0d", $time,
							want.calibration_progress, got.calibration_progress);
					if (got !== want) failed = 1;
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic drain();
		in_valid <= 0;
		while (pending_decisions.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// random features: mostly small values, sometimes the full range
	function automatic feat_t rand_feat();
		case ($urandom_range(3))
			0: return feat_t'($urandom_range(16'hFFFF));
			1: return feat_t'($urandom_range(2000));
			default: return feat_t'($urandom_range(300, 1500));
		endcase
	endfunction

	task automatic random_phase(int unsigned words);
		feat_t f [NUM_FEAT];
		op_t op;
		int unsigned r;
		decision_t none;
		none = '0;
		for (int unsigned n = 0; n < words; n++) begin
			for (int k = 0; k < NUM_FEAT; k++) f[k] = rand_feat();
			r = $urandom_range(99);
			// calibrate while filling, detect once calibrated, rare restarts and unused codes
			if (r < 2) op = OP_RESTART;
			else if (r < 4) op = OP_UNUSED;
			else if (!cal_done) op = (r < 85) ? OP_CALIB : OP_DETECT;
			else op = (r < 92) ? OP_DETECT : OP_CALIB;
			send_word(op, f, 0, none);
		end
	endtask

	stim_row_t dir_tab [$];

	function automatic stim_row_t mk(op_t op, feat_t a, feat_t b, feat_t c, feat_t v,
			bit he, decision_t e);
		stim_row_t s;
		s.op = op; s.f = '{a, b, c, v}; s.has_exp = he; s.exp = e;
		return s;
	endfunction

	initial begin
		decision_t z;
		feat_t f [NUM_FEAT];
		z = '0;
		failed = 0; cycles = 0;
		arst_n = 0;
		in_valid = 0; operation = OP_CALIB;
		energy_level = 0; centroid_hz = 0; crossing_rate = 0; log_spectrum_variance = 0;
		out_stall = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		send_idle_pct = 24; recv_idle_pct = 50;
		weights_q = WEIGHTS_RST; margins_q = MARGINS_RST; ratio_q = RATIO_RST;
		cal_done = 0; sample_cnt = 0; ring_ptr = 0;
		for (int k = 0; k < NUM_FEAT; k++) limit_q[k] = LIMIT_RST[k];
		for (int i = 0; i < HIST_N; i++) vote_ring[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: uncalibrated detect, odd code, restart, extremes
		dir_tab.push_back(mk(OP_DETECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, z));
		dir_tab.push_back(mk(OP_UNUSED, 0, 0, 0, 0, 1, z));
		dir_tab.push_back(mk(OP_CALIB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
			'{1'b0, 10'd0, 1'b0, 7'd1}));
		dir_tab.push_back(mk(OP_CALIB, 0, 0, 0, 0, 1, '{1'b0, 10'd0, 1'b0, 7'd2}));
		dir_tab.push_back(mk(OP_RESTART, 0, 0, 0, 0, 1, z));
		dir_tab.push_back(mk(OP_CALIB, 16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0, 1,
			'{1'b0, 10'd0, 1'b0, 7'd1}));
		foreach (dir_tab[i])
			send_word(dir_tab[i].op, dir_tab[i].f, dir_tab[i].has_exp, dir_tab[i].exp);
		drain();

		// max margins and weights: full calibration with saturating thresholds
		write_reg(REG_WEIGHTS, 32'hFFFF_FFFF);
		write_reg(REG_MARGINS, 32'hFFFF_FFFF);
		write_reg(REG_RATIO, 8'd0);
		for (int n = 1; n < CAL_N; n++) begin
			for (int k = 0; k < NUM_FEAT; k++) f[k] = feat_t'($urandom_range(16'hFFFF));
			send_word(OP_CALIB, f, 0, z);
		end
		// full store: ignored calibrate, then detects at both extremes and a restart
		send_word(OP_CALIB, '{16'd0, 16'd0, 16'd0, 16'd0}, 0, z);
		send_word(OP_DETECT, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, z);
		send_word(OP_DETECT, '{16'd0, 16'd0, 16'd0, 16'd0}, 0, z);
		send_word(OP_RESTART, '{16'd0, 16'd0, 16'd0, 16'd0}, 1, z);
		drain();

		// zero margins: thresholds fall to the floors
		write_reg(REG_MARGINS, 32'h0);
		write_reg(REG_RATIO, 8'hFF);
		send_idle_pct = 24; recv_idle_pct = 50;
		random_phase(140);
		drain();

		write_reg(REG_WEIGHTS, $urandom);
		write_reg(REG_MARGINS, 32'h1818_1818);
		write_reg(REG_RATIO, 8'd64);
		send_idle_pct = 50; recv_idle_pct = 24;
		random_phase(140);
		drain();

		write_reg(REG_WEIGHTS, 32'h0);
		write_reg(REG_MARGINS, $urandom);
		write_reg(REG_RATIO, $urandom_range(255));
		send_idle_pct = 0; recv_idle_pct = 0;
		random_phase(60);
		write_reg_idle_weights();
		random_phase(70);
		drain();

		if (!failed)
			$display("voice_activity_decision_tb OK");
		else
			$display("voice_activity_decision_tb NOT OK");
		$finish;
	end

	// mid-run weight change, only once the pipeline is empty
	task automatic write_reg_idle_weights();
		drain();
		write_reg(REG_WEIGHTS, $urandom);
	endtask

endmodule
`default_nettype wire
